[design/brrr_pkg.sv]
// Package: transaction types and status/command codes for the bridge registry.
`default_nettype none

package brrr_pkg;

    localparam int BRRR_TABLE_ENTRIES = 64;

    localparam logic [1:0] CMD_LINK   = 2'd0;
    localparam logic [1:0] CMD_RETIRE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;
    // spare code: dropped without a result
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [3:0] ST_INSERTED    = 4'd0;
    localparam logic [3:0] ST_IDEMPOTENT  = 4'd1;
    localparam logic [3:0] ST_REVIVED     = 4'd2;
    localparam logic [3:0] ST_CONFLICT    = 4'd3;
    localparam logic [3:0] ST_FULL        = 4'd4;
    localparam logic [3:0] ST_REJECTED    = 4'd5;
    localparam logic [3:0] ST_MISSING     = 4'd6;
    localparam logic [3:0] ST_LIVE        = 4'd7;
    localparam logic [3:0] ST_RETIRED     = 4'd8;
    localparam logic [3:0] ST_RETIRED_KEY = 4'd9;
    localparam logic [3:0] ST_RETIRE_NONE = 4'd10;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] native_key;
        logic [63:0] target_address;
        logic [63:0] range_start;
        logic [63:0] range_length;
    } brrr_cmd_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [63:0] result_key;
        logic [63:0] result_target;
        logic [31:0] generation;
        logic        last;
    } brrr_res_t;

endpackage

`default_nettype wire

[design/bridge_registry_range_retire.sv]
// Top level: keyed bridge table with link, range retire and lookup.
//
//  channel | payload     | handshake            | per transaction
//  --------+-------------+----------------------+------------------------------
//  cmd     | brrr_cmd_t  | cmd_valid/cmd_stall  | one command
//  res     | brrr_res_t  | res_valid/res_stall  | one result, last on final one
//
// Each table slot is read from memory, then compared. Link and lookup stop
// early on a key hit; retire walks all slots. Rejected links and zero-length
// retires go straight to the result. The registered table read sets this order.
// Reset clears the slot valid bits at once; no clearing pass is needed.
// A stalled result holds the sequencer only when it must emit the next result.
`default_nettype none

module bridge_registry_range_retire
    import brrr_pkg::*;
#(
    parameter int TABLE_ENTRIES = BRRR_TABLE_ENTRIES
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_stall,
    input  wire brrr_cmd_t cmd_data,
    output logic           res_valid,
    input  wire logic      res_stall,
    output brrr_res_t      res_data
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

    // one table row: live flag, key, target, generation
    typedef struct packed {
        logic        live;
        logic [63:0] key;
        logic [63:0] target;
        logic [31:0] gen;
    } entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_DONE
    } state_t;

    function automatic logic [31:0] bump(input logic [31:0] g);
        bump = (g == 32'hFFFF_FFFF) ? g : g + 32'd1;
    endfunction

    // table memory, registered read
    entry_t mem [TABLE_ENTRIES];
    entry_t rd_reg;
    logic              rd_en;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic [63:0]       key_reg, key_next;
    logic [63:0]       tgt_reg, tgt_next;
    logic [63:0]       start_reg, start_next;
    logic [63:0]       range_end_reg, range_end_next;
    logic              rej_reg, rej_next;
    logic              free_found_reg, free_found_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic              pend_reg, pend_next;
    logic [63:0]       pend_key_reg, pend_key_next;
    logic [31:0]       pend_gen_reg, pend_gen_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic              res_valid_reg, res_valid_next;
    brrr_res_t         res_data_reg, res_data_next;

    logic [64:0]       end_sum;
    logic              can_emit;
    logic              hit;
    logic              in_range;
    logic              last_idx;
    logic [31:0]       gen_bumped;

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // saturating range end
    assign end_sum  = {1'b0, cmd_data.range_start} + {1'b0, cmd_data.range_length};
    assign can_emit = !res_valid_reg || !res_stall;

    assign hit        = valid_reg[idx_reg] && (rd_reg.key == key_reg);
    assign in_range   = valid_reg[idx_reg] && rd_reg.live
                        && (rd_reg.target >= start_reg) && (rd_reg.target < range_end_reg);
    assign last_idx   = (idx_reg == IDX_LAST);
    assign gen_bumped = bump(rd_reg.gen);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        tgt_next        = tgt_reg;
        start_next      = start_reg;
        range_end_next  = range_end_reg;
        rej_next        = rej_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        pend_next       = pend_reg;
        pend_key_next   = pend_key_reg;
        pend_gen_next   = pend_gen_reg;
        valid_next      = valid_reg;
        res_valid_next  = res_valid_reg && res_stall;
        res_data_next   = res_data_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = rd_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next        = cmd_data.command;
                    key_next        = cmd_data.native_key;
                    tgt_next        = cmd_data.target_address;
                    start_next      = cmd_data.range_start;
                    range_end_next  = end_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : end_sum[63:0];
                    rej_next        = 1'b0;
                    free_found_next = 1'b0;
                    pend_next       = 1'b0;
                    idx_next        = '0;
                    case (cmd_data.command)
                        CMD_LINK:
                        begin
                            if (cmd_data.native_key == 64'd0 || cmd_data.target_address == 64'd0)
                            begin
                                rej_next   = 1'b1;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        CMD_RETIRE:
                        begin
                            state_next = (cmd_data.range_length == 64'd0) ? S_DONE : S_READ;
                        end
                        CMD_LOOKUP:
                        begin
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                rd_en      = 1'b1;
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                case (cmd_reg)
                    CMD_LINK:
                    begin
                        if (hit)
                        begin
                            if (can_emit)
                            begin
                                res_valid_next           = 1'b1;
                                res_data_next.result_key = key_reg;
                                res_data_next.last       = 1'b1;
                                if (!rd_reg.live)
                                begin
                                    wr_en   = 1'b1;
                                    wr_data = '{live: 1'b1, key: rd_reg.key,
                                                target: tgt_reg, gen: gen_bumped};
                                    res_data_next.status        = ST_REVIVED;
                                    res_data_next.result_target = 64'd0;
                                    res_data_next.generation    = gen_bumped;
                                end
                                else
                                begin
                                    res_data_next.status = (rd_reg.target == tgt_reg)
                                                           ? ST_IDEMPOTENT : ST_CONFLICT;
                                    res_data_next.result_target = rd_reg.target;
                                    res_data_next.generation    = rd_reg.gen;
                                end
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            if (!valid_reg[idx_reg] && !free_found_reg)
                            begin
                                free_found_next = 1'b1;
                                free_idx_next   = idx_reg;
                            end
                            idx_next   = idx_reg + IDX_W'(1);
                            state_next = last_idx ? S_DONE : S_READ;
                        end
                    end

                    CMD_LOOKUP:
                    begin
                        if (hit)
                        begin
                            if (can_emit)
                            begin
                                res_valid_next           = 1'b1;
                                res_data_next.result_key = key_reg;
                                res_data_next.generation = rd_reg.gen;
                                res_data_next.last       = 1'b1;
                                if (rd_reg.live)
                                begin
                                    res_data_next.status        = ST_LIVE;
                                    res_data_next.result_target = rd_reg.target;
                                end
                                else
                                begin
                                    res_data_next.status        = ST_RETIRED;
                                    res_data_next.result_target = 64'd0;
                                end
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            idx_next   = idx_reg + IDX_W'(1);
                            state_next = last_idx ? S_DONE : S_READ;
                        end
                    end

                    default:
                    begin
                        // retire: one result held back so the final one carries last
                        if (in_range)
                        begin
                            if (!pend_reg || can_emit)
                            begin
                                if (pend_reg)
                                begin
                                    res_valid_next = 1'b1;
                                    res_data_next  = '{status: ST_RETIRED_KEY,
                                                       result_key: pend_key_reg,
                                                       result_target: 64'd0,
                                                       generation: pend_gen_reg,
                                                       last: 1'b0};
                                end
                                wr_en   = 1'b1;
                                wr_data = '{live: 1'b0, key: rd_reg.key,
                                            target: 64'd0, gen: gen_bumped};
                                pend_next     = 1'b1;
                                pend_key_next = rd_reg.key;
                                pend_gen_next = gen_bumped;
                                idx_next      = idx_reg + IDX_W'(1);
                                state_next    = last_idx ? S_DONE : S_READ;
                            end
                        end
                        else
                        begin
                            idx_next   = idx_reg + IDX_W'(1);
                            state_next = last_idx ? S_DONE : S_READ;
                        end
                    end
                endcase
            end

            S_DONE:
            begin
                if (can_emit)
                begin
                    res_valid_next = 1'b1;
                    res_data_next  = '{status: ST_MISSING, result_key: key_reg,
                                       result_target: 64'd0, generation: 32'd0,
                                       last: 1'b1};
                    case (cmd_reg)
                        CMD_LINK:
                        begin
                            if (rej_reg)
                            begin
                                res_data_next.status = ST_REJECTED;
                            end
                            else if (free_found_reg)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = free_idx_reg;
                                wr_data = '{live: 1'b1, key: key_reg,
                                            target: tgt_reg, gen: 32'd1};
                                valid_next[free_idx_reg] = 1'b1;
                                res_data_next.status     = ST_INSERTED;
                                res_data_next.generation = 32'd1;
                            end
                            else
                            begin
                                res_data_next.status = ST_FULL;
                            end
                        end
                        CMD_RETIRE:
                        begin
                            if (pend_reg)
                            begin
                                res_data_next.status     = ST_RETIRED_KEY;
                                res_data_next.result_key = pend_key_reg;
                                res_data_next.generation = pend_gen_reg;
                            end
                            else
                            begin
                                res_data_next.status = ST_RETIRE_NONE;
                            end
                        end
                        default:
                        begin
                            res_data_next.status = ST_MISSING;
                        end
                    endcase
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // table memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= mem[idx_reg];
        end
    end

    // sequencer state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            cmd_reg        <= CMD_LINK;
            key_reg        <= '0;
            tgt_reg        <= '0;
            start_reg      <= '0;
            range_end_reg  <= '0;
            rej_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            pend_reg       <= 1'b0;
            pend_key_reg   <= '0;
            pend_gen_reg   <= '0;
            valid_reg      <= '0;
            res_valid_reg  <= 1'b0;
            res_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cmd_reg        <= cmd_next;
            key_reg        <= key_next;
            tgt_reg        <= tgt_next;
            start_reg      <= start_next;
            range_end_reg  <= range_end_next;
            rej_reg        <= rej_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            pend_reg       <= pend_next;
            pend_key_reg   <= pend_key_next;
            pend_gen_reg   <= pend_gen_next;
            valid_reg      <= valid_next;
            res_valid_reg  <= res_valid_next;
            res_data_reg   <= res_data_next;
        end
    end

endmodule

`default_nettype wire

[design/brrr_checker.sv]
// Checker: port-level properties of the bridge registry, bound to the top level.
`default_nettype none

module brrr_checker
    import brrr_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      cmd_valid,
    input wire logic      cmd_stall,
    input wire brrr_cmd_t cmd_data,
    input wire logic      res_valid,
    input wire logic      res_stall,
    input wire brrr_res_t res_data
);

    // a stalled result stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    // a real command keeps the block busy in the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && (cmd_data.command != CMD_UNUSED) |=> cmd_stall)
        else $error("command accepted without going busy");

    // only retire produces more than one result
    a_multi: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.last |-> res_data.status == ST_RETIRED_KEY)
        else $error("non-final result with wrong status");

    // a fresh insert starts at generation one
    a_insert: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_data.status == ST_INSERTED)
        |-> (res_data.generation == 32'd1) && res_data.last)
        else $error("insert with wrong generation");

    // a tombstoned entry reports no target and a nonzero generation
    a_tomb: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_data.status == ST_RETIRED_KEY)
        |-> (res_data.result_target == 64'd0) && (res_data.generation != 32'd0))
        else $error("retired key result malformed");

endmodule

bind bridge_registry_range_retire brrr_checker u_brrr_checker (.*);

`default_nettype wire
